### design/pag_pkg.sv
// ----------------------------------------------------------------------------
// Preferential attachment graph generator package
// Shared constants, payload types and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package pag_pkg;

  localparam int MAX_NODES          = 1024;
  localparam int MAX_LINKS_PER_NODE = 16;
  localparam int LIST_DEPTH         = 65536;

  localparam int NODE_W  = 10;
  localparam int NODE_CW = $clog2(MAX_NODES) + 1;
  localparam int ADDR_W  = $clog2(LIST_DEPTH);
  localparam int LEN_W   = ADDR_W + 1;
  localparam int SLOT_W  = $clog2(MAX_LINKS_PER_NODE);
  localparam int LINK_W  = SLOT_W + 1;
  localparam int DEG_W   = 10;
  localparam int WORD_W  = 32;
  localparam int CFG_W   = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [DEG_W-1:0] DEG_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_LINKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 1'b1;

  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_DRAW    = 1'b1;

  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] random_word;
  } in_t;

  typedef struct packed {
    logic [NODE_W-1:0] new_node;
    logic [NODE_W-1:0] target_node;
    logic [DEG_W-1:0]  target_degree;
    logic              status;
    logic              last;
  } out_t;

  typedef struct packed {
    logic accept;
    logic restart_init;
    logic clr_step;
    logic push_i;
    logic push_j;
    logic mod_step;
    logic ep_read;
    logic insert;
    logic link_rd;
    logic link_wr;
    logic finish;
    logic status_out;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic list_empty;
    logic full;
    logic clr_done;
    logic m0_small;
    logic pair_last;
    logic mod_last;
    logic need_emit;
    logic last_link;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

### design/pag_ctrl.sv
// ----------------------------------------------------------------------------
// Preferential attachment graph generator controller
// Sequences restart, draw, modulo, insertion and link emission steps.
// ----------------------------------------------------------------------------
`default_nettype none

module pag_ctrl
  import pag_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_CLEAR, S_PAIR_I, S_PAIR_J, S_MOD, S_READ,
    S_INSERT, S_CHECK, S_LINK_RD, S_LINK_WR, S_FINISH, S_STATUS
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.op == OP_RESTART) begin
          cmd.restart_init = 1'b1;
          state_next       = S_CLEAR;
        end else if (sts.list_empty) begin
          state_next = S_IDLE;
        end else if (sts.full) begin
          state_next = S_STATUS;
        end else begin
          state_next = S_MOD;
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_next = sts.m0_small ? S_IDLE : S_PAIR_I;
        end
      end
      S_PAIR_I: begin
        cmd.push_i = 1'b1;
        state_next = S_PAIR_J;
      end
      S_PAIR_J: begin
        cmd.push_j = 1'b1;
        state_next = sts.pair_last ? S_IDLE : S_PAIR_I;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.ep_read = 1'b1;
        state_next  = S_INSERT;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = sts.need_emit ? S_LINK_RD : S_IDLE;
      end
      S_LINK_RD: begin
        cmd.link_rd = 1'b1;
        state_next  = S_LINK_WR;
      end
      S_LINK_WR: begin
        if (!sts.out_busy) begin
          cmd.link_wr = 1'b1;
          state_next  = sts.last_link ? S_FINISH : S_LINK_RD;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      S_STATUS: begin
        if (!sts.out_busy) begin
          cmd.status_out = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/pag_dp.sv
// ----------------------------------------------------------------------------
// Preferential attachment graph generator datapath
// Configuration, endpoint and degree memories, modulo unit and target set.
// ----------------------------------------------------------------------------
`default_nettype none

module pag_dp
  import pag_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire in_t                  in_data,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_t                      out_data
);

  logic [LINK_W-1:0]  cfg_links;
  logic [CFG_W-1:0]   cfg_seed;
  logic               op_r;
  logic [WORD_W-1:0]  word;
  logic [LEN_W-1:0]   rem;
  logic [4:0]         mod_cnt;
  logic [LEN_W-1:0]   list_len;
  logic [NODE_CW-1:0] node_count;
  logic [NODE_CW-1:0] m0;
  logic [NODE_W-1:0]  clr_addr;
  logic [NODE_CW-1:0] pi;
  logic [NODE_CW-1:0] pj;
  logic [NODE_W-1:0]  chosen [MAX_LINKS_PER_NODE];
  logic [LINK_W-1:0]  chosen_count;
  logic [LINK_W-1:0]  link_k;
  logic [NODE_W-1:0]  ep_rdata;
  logic [DEG_W-1:0]   deg_rdata;

  logic [NODE_W-1:0]  ep_mem  [LIST_DEPTH];
  logic [DEG_W-1:0]   deg_mem [MAX_NODES];

  logic [LINK_W-1:0]  m_eff;
  logic [NODE_CW-1:0] m0_calc;
  logic [NODE_CW-1:0] seed_ext;
  logic [NODE_CW-1:0] m_ext;
  logic [LEN_W:0]     rem_sh;
  logic [LEN_W:0]     len_ext;
  logic [LEN_W:0]     len_need;
  logic [NODE_W-1:0]  cur_target;
  logic [DEG_W-1:0]   deg_inc;

  logic [MAX_LINKS_PER_NODE-1:0] less;
  logic [MAX_LINKS_PER_NODE-1:0] same;
  logic [LINK_W-1:0]             pos;
  logic                          do_insert;

  logic               ep_we;
  logic [NODE_W-1:0]  ep_wdata;
  logic               deg_we;
  logic [NODE_W-1:0]  deg_waddr;
  logic [DEG_W-1:0]   deg_wdata;

  always_comb begin
    if (cfg_links == '0) begin
      m_eff = LINK_W'(1);
    end else if (cfg_links > LINK_W'(MAX_LINKS_PER_NODE)) begin
      m_eff = LINK_W'(MAX_LINKS_PER_NODE);
    end else begin
      m_eff = cfg_links;
    end
    seed_ext = NODE_CW'(cfg_seed);
    m_ext    = NODE_CW'(m_eff);
    m0_calc  = (seed_ext <= m_ext) ? seed_ext + m_ext : seed_ext;
    if (m0_calc > NODE_CW'(MAX_NODES)) begin
      m0_calc = NODE_CW'(MAX_NODES);
    end
  end

  assign rem_sh   = {rem, word[WORD_W-1]};
  assign len_ext  = {1'b0, list_len};
  assign len_need = len_ext + (LEN_W+1)'({m_eff, 1'b0});

  assign cur_target = chosen[link_k[SLOT_W-1:0]];
  assign deg_inc    = (deg_rdata == DEG_MAX) ? DEG_MAX : deg_rdata + 1'b1;

  always_comb begin
    for (int k = 0; k < MAX_LINKS_PER_NODE; k++) begin
      less[k] = (LINK_W'(k) < chosen_count) && (chosen[k] < ep_rdata);
      same[k] = (LINK_W'(k) < chosen_count) && (chosen[k] == ep_rdata);
    end
    pos       = LINK_W'($countones(less));
    do_insert = (chosen_count < LINK_W'(MAX_LINKS_PER_NODE)) && (same == '0);
  end

  assign sts.op         = op_r;
  assign sts.list_empty = (list_len == '0);
  assign sts.full       = (node_count >= NODE_CW'(MAX_NODES)) ||
                          (len_need > (LEN_W+1)'(LIST_DEPTH));
  assign sts.clr_done   = (clr_addr == NODE_W'(MAX_NODES - 1));
  assign sts.m0_small   = (m0 < NODE_CW'(2));
  assign sts.pair_last  = (pj == m0 - 1'b1) && (pi + NODE_CW'(2) == m0);
  assign sts.mod_last   = (mod_cnt == 5'd31);
  assign sts.need_emit  = (chosen_count >= m_eff);
  assign sts.last_link  = (link_k + 1'b1 == chosen_count);
  assign sts.out_busy   = out_valid && !out_ready;

  always_comb begin
    ep_we     = 1'b0;
    ep_wdata  = '0;
    deg_we    = 1'b0;
    deg_waddr = '0;
    deg_wdata = '0;
    if (cmd.clr_step) begin
      deg_we    = 1'b1;
      deg_waddr = clr_addr;
      deg_wdata = ({1'b0, clr_addr} < m0) ? DEG_W'(m0 - 1'b1) : '0;
    end
    if (cmd.push_i) begin
      ep_we    = 1'b1;
      ep_wdata = pi[NODE_W-1:0];
    end
    if (cmd.push_j) begin
      ep_we    = 1'b1;
      ep_wdata = pj[NODE_W-1:0];
    end
    if (cmd.link_rd) begin
      ep_we    = 1'b1;
      ep_wdata = node_count[NODE_W-1:0];
    end
    if (cmd.link_wr) begin
      ep_we     = 1'b1;
      ep_wdata  = cur_target;
      deg_we    = 1'b1;
      deg_waddr = cur_target;
      deg_wdata = deg_inc;
    end
    if (cmd.finish) begin
      deg_we    = 1'b1;
      deg_waddr = node_count[NODE_W-1:0];
      deg_wdata = DEG_W'(chosen_count);
    end
  end

  always_ff @(posedge clk) begin
    if (ep_we) begin
      ep_mem[list_len[ADDR_W-1:0]] <= ep_wdata;
    end
    if (cmd.ep_read) begin
      ep_rdata <= ep_mem[rem[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    if (cmd.link_rd) begin
      deg_rdata <= deg_mem[cur_target];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_links    <= LINK_W'(2);
      cfg_seed     <= CFG_W'(3);
      list_len     <= '0;
      node_count   <= '0;
      chosen_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_LINKS: cfg_links <= cfg_data[LINK_W-1:0];
          CFG_SEED:  cfg_seed  <= cfg_data;
          default:   cfg_seed  <= cfg_seed;
        endcase
      end
      if (cmd.restart_init) begin
        list_len     <= '0;
        chosen_count <= '0;
        node_count   <= m0_calc;
      end
      if (ep_we) begin
        list_len <= list_len + 1'b1;
      end
      if (cmd.insert && do_insert) begin
        chosen_count <= chosen_count + 1'b1;
      end
      if (cmd.finish) begin
        node_count   <= node_count + 1'b1;
        chosen_count <= '0;
      end
      if (cmd.link_wr || cmd.status_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_data.op;
      word    <= in_data.random_word;
      rem     <= '0;
      mod_cnt <= '0;
    end
    if (cmd.mod_step) begin
      rem     <= (rem_sh >= len_ext) ? LEN_W'(rem_sh - len_ext) : LEN_W'(rem_sh);
      word    <= {word[WORD_W-2:0], 1'b0};
      mod_cnt <= mod_cnt + 1'b1;
    end
    if (cmd.restart_init) begin
      m0       <= m0_calc;
      clr_addr <= '0;
      pi       <= '0;
      pj       <= NODE_CW'(1);
    end
    if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
    if (cmd.push_j) begin
      if (pj == m0 - 1'b1) begin
        pi <= pi + 1'b1;
        pj <= pi + NODE_CW'(2);
      end else begin
        pj <= pj + 1'b1;
      end
    end
    if (cmd.insert) begin
      link_k <= '0;
      if (do_insert) begin
        for (int k = 0; k < MAX_LINKS_PER_NODE; k++) begin
          if (LINK_W'(k) == pos) begin
            chosen[k] <= ep_rdata;
          end else if (LINK_W'(k) > pos) begin
            chosen[k] <= chosen[(k + MAX_LINKS_PER_NODE - 1) % MAX_LINKS_PER_NODE];
          end
        end
      end
    end
    if (cmd.link_wr) begin
      link_k                 <= link_k + 1'b1;
      out_data.new_node      <= node_count[NODE_W-1:0];
      out_data.target_node   <= cur_target;
      out_data.target_degree <= deg_inc;
      out_data.status        <= 1'b0;
      out_data.last          <= (link_k + 1'b1 == chosen_count);
    end
    if (cmd.status_out) begin
      out_data.new_node      <= '0;
      out_data.target_node   <= '0;
      out_data.target_degree <= '0;
      out_data.status        <= 1'b1;
      out_data.last          <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### design/preferential_attachment_graph_gen_unit.sv
// ----------------------------------------------------------------------------
// Preferential attachment graph generator
// Grows a scale-free graph one drawn endpoint per input transfer.
// ----------------------------------------------------------------------------
// A draw runs through the bit-serial modulo unit (32 steps). A draw that
// completes a node adds a read and a write step per link, the write waiting
// while the output is stalled, plus a finish step for the new node. A restart
// runs a degree clearing pass over all nodes, then one endpoint write per
// cycle for the seed clique. Reset clears the list, node count, target set
// and output valid; draws are ignored until the first restart.
`default_nettype none

module preferential_attachment_graph_gen_unit
  import pag_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_t                      out_data
);

  cmd_t cmd;
  sts_t sts;

  pag_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pag_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### design/pag_checker.sv
// ----------------------------------------------------------------------------
// Preferential attachment graph generator port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pag_checker
  import pag_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result transfer changed.");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.last)
    else $error("Status result without last.");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |->
      out_data.new_node == '0 && out_data.target_node == '0 &&
      out_data.target_degree == '0)
    else $error("Status result carries nonzero fields.");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("Block not idle after reset.");

endmodule

bind preferential_attachment_graph_gen_unit pag_checker u_pag_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

### verif/preferential_attachment_graph_gen_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Preferential attachment graph generator testbench
// Drives restarts and random draws through the input channel, tracks the
// growing graph in a local model, and checks every emitted link and status
// transfer against the links that the model predicts.
// ----------------------------------------------------------------------------
`default_nettype none

module preferential_attachment_graph_gen_unit_tb;
  import pag_pkg::*;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  preferential_attachment_graph_gen_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  in_t pending_items[$];
  out_t expected_links[$];
  int error_count = 0;
  bit burst_mode = 0;
  int send_gap = 0;
  int recv_stall = 0;

  // Graph state as the block should hold it.
  bit [9:0] endpoints[LIST_DEPTH];
  int unsigned endpoint_count;
  bit [9:0] degree[MAX_NODES];
  int unsigned node_total;
  int unsigned picked[MAX_LINKS_PER_NODE];
  int unsigned picked_count;
  bit [4:0] links_reg;
  bit [5:0] seed_reg;

  function automatic int unsigned link_count();
    int unsigned m;
    m = links_reg;
    if (m < 1) m = 1;
    if (m > MAX_LINKS_PER_NODE) m = MAX_LINKS_PER_NODE;
    return m;
  endfunction

  function automatic void add_endpoint(int unsigned node);
    if (endpoint_count < LIST_DEPTH) begin
      endpoints[endpoint_count] = node[9:0];
      endpoint_count++;
    end
    if (node < MAX_NODES && degree[node] < DEG_MAX) degree[node]++;
  endfunction

  function automatic void grow_graph(in_t item);
    int unsigned m, m0, node, pos;
    out_t link;
    if (item.op == OP_RESTART) begin
      m = link_count();
      m0 = seed_reg;
      if (m0 <= m) m0 += m;
      if (m0 > MAX_NODES) m0 = MAX_NODES;
      foreach (degree[i]) degree[i] = '0;
      endpoint_count = 0;
      picked_count = 0;
      for (int unsigned i = 0; i < m0; i++)
        for (int unsigned j = i + 1; j < m0; j++) begin
          add_endpoint(i);
          add_endpoint(j);
        end
      node_total = m0;
      return;
    end
    if (endpoint_count == 0) return;
    m = link_count();
    if (node_total >= MAX_NODES || endpoint_count + 2 * m > LIST_DEPTH) begin
      link = '0;
      link.status = 1'b1;
      link.last = 1'b1;
      expected_links.push_back(link);
      return;
    end
    node = endpoints[item.random_word % endpoint_count];
    if (picked_count < MAX_LINKS_PER_NODE) begin
      pos = 0;
      while (pos < picked_count && picked[pos] < node) pos++;
      if (!(pos < picked_count && picked[pos] == node)) begin
        for (int unsigned k = picked_count; k > pos; k--) picked[k] = picked[k-1];
        picked[pos] = node;
        picked_count++;
      end
    end
    if (picked_count < m) return;
    for (int unsigned k = 0; k < picked_count; k++) begin
      add_endpoint(node_total);
      add_endpoint(picked[k]);
      link.new_node = node_total[9:0];
      link.target_node = picked[k][9:0];
      link.target_degree = degree[picked[k]];
      link.status = 1'b0;
      link.last = (k + 1 == picked_count);
      expected_links.push_back(link);
    end
    picked_count = 0;
    node_total++;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) grow_graph(in_data);
      if (!in_valid || in_ready) begin
        if (send_gap > 0 || pending_items.size() == 0) begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          send_gap = burst_mode ? 0 : $urandom_range(0, 5);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_links.size() == 0) begin
          $error("unexpected result transfer %p", out_data);
          error_count++;
        end else begin
          want = expected_links.pop_front();
          if (out_data.new_node !== want.new_node) begin
            $error("new_node: expected %0d, got %0d", want.new_node, out_data.new_node);
            error_count++;
          end
          if (out_data.target_node !== want.target_node) begin
            $error("target_node: expected %0d, got %0d",
                   want.target_node, out_data.target_node);
            error_count++;
          end
          if (out_data.target_degree !== want.target_degree) begin
            $error("target_degree: expected %0d, got %0d",
                   want.target_degree, out_data.target_degree);
            error_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            error_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_data.last);
            error_count++;
          end
        end
        recv_stall = burst_mode ? 0 : $urandom_range(0, 5);
      end
      out_ready <= (recv_stall == 0);
      if (recv_stall > 0) recv_stall--;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    if (index == CFG_LINKS) links_reg = value[4:0];
    else seed_reg = value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_item(input logic op, input logic [31:0] word);
    in_t item;
    item.op = op;
    item.random_word = word;
    pending_items.push_back(item);
  endtask

  task automatic queue_draws(input int count, input int restart_pct);
    for (int i = 0; i < count; i++)
      queue_item(($urandom_range(0, 99) < restart_pct) ? OP_RESTART : OP_DRAW, $urandom);
  endtask

  // Restarts and incomplete draws produce nothing, so the block may still be
  // busy once the last link is seen; the trailing wait covers a full rebuild.
  task automatic wait_quiet();
    wait (pending_items.size() == 0 && !in_valid && expected_links.size() == 0);
    repeat (5000) @(posedge clk);
  endtask

  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_LINKS;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    links_reg = 5'd2;
    seed_reg = 6'd3;
    endpoint_count = 0;
    node_total = 0;
    picked_count = 0;
    foreach (degree[i]) degree[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Draws before the first restart are ignored.
    queue_item(OP_DRAW, 32'h0000_0000);
    queue_item(OP_DRAW, 32'hFFFF_FFFF);
    queue_item(OP_RESTART, 32'h0);
    queue_item(OP_DRAW, 32'h0000_0000);
    queue_item(OP_DRAW, 32'hFFFF_FFFF);
    queue_item(OP_DRAW, 32'h0000_0000);
    queue_item(OP_DRAW, 32'h8000_0000);
    queue_item(OP_DRAW, 32'h0000_0001);
    queue_item(OP_DRAW, 32'h5555_5555);
    queue_item(OP_DRAW, 32'hAAAA_AAAA);
    queue_item(OP_RESTART, 32'hFFFF_FFFF);
    queue_item(OP_DRAW, 32'h7FFF_FFFF);
    wait_quiet();
    queue_draws(100, 5);
    wait_quiet();

    // Zero link count clamps to one; zero seed gives a single node clique.
    write_reg(CFG_LINKS, 6'd0);
    write_reg(CFG_SEED, 6'd0);
    burst_mode = 1;
    queue_item(OP_RESTART, 32'h0);
    queue_draws(30, 3);
    wait_quiet();

    // Oversized link count clamps to the maximum.
    write_reg(CFG_LINKS, 6'd31);
    write_reg(CFG_SEED, 6'd0);
    burst_mode = 0;
    queue_item(OP_RESTART, 32'h0);
    queue_draws(60, 0);
    wait_quiet();

    // Lower the link count while a target set is partly collected.
    write_reg(CFG_LINKS, 6'd6);
    write_reg(CFG_SEED, 6'd10);
    queue_item(OP_RESTART, 32'h0);
    queue_draws(3, 0);
    wait_quiet();
    write_reg(CFG_LINKS, 6'd2);
    queue_draws(10, 0);
    wait_quiet();

    write_reg(CFG_LINKS, 6'd5);
    write_reg(CFG_SEED, 6'd63);
    queue_item(OP_RESTART, 32'h0);
    queue_draws(50, 4);
    wait_quiet();

    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
design/pag_pkg.sv
design/pag_ctrl.sv
design/pag_dp.sv
design/preferential_attachment_graph_gen_unit.sv
design/pag_checker.sv
verif/preferential_attachment_graph_gen_unit_tb.sv
